// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/mbeg_pkg.sv =====
package mbeg_pkg;

    localparam int MV_W       = 11;
    localparam int COEF_W     = 12;
    localparam int VAL_W      = 13;
    localparam int WORD_W     = 26;
    localparam int LEN_W      = 5;
    localparam int MB_W       = 14;
    localparam int TOT_W      = 40;
    localparam int QP_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    // Widest block index the job record can carry (block sizes up to 256).
    localparam int IDX_MAX_W  = 8;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int K_W        = 4;

    localparam logic [QP_W-1:0] RAW_BASE = 8'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_MC_EN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TR_EN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_EN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_QP = 2'd3;

    typedef enum logic [2:0] {
        JOB_START = 3'd0,
        JOB_VEC   = 3'd1,
        JOB_RAW   = 3'd2,
        JOB_BLK   = 3'd3,
        JOB_ZBLK  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic signed [VAL_W-1:0]   val0;
        logic signed [VAL_W-1:0]   val1;
        logic                      bank;
        logic [IDX_MAX_W-1:0]      last_idx;
    } t_job;

    typedef struct packed {
        logic vld;
        logic bank;
    } t_free;

endpackage

// ===== design/mbeg_queue.sv =====
module mbeg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mbeg_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output mbeg_pkg::t_job o_head,
    output logic          o_empty
);

    mbeg_pkg::t_job                r_slot [mbeg_pkg::Q_DEPTH];
    logic [mbeg_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [mbeg_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [mbeg_pkg::Q_PTR_W:0]    r_count;

    assign o_full  = (r_count == (mbeg_pkg::Q_PTR_W+1)'(mbeg_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/mbeg_front.sv =====
module mbeg_front #(
    parameter int BLOCK_COEFFS = 64,
    parameter int IDX_W        = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mbeg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mbeg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_mode,
    input  logic                               i_inter_flag,
    input  logic signed [mbeg_pkg::MV_W-1:0]   i_mv_x,
    input  logic signed [mbeg_pkg::MV_W-1:0]   i_mv_y,
    input  logic                               i_up_present,
    input  logic signed [mbeg_pkg::MV_W-1:0]   i_up_mv_x,
    input  logic signed [mbeg_pkg::MV_W-1:0]   i_up_mv_y,
    input  logic                               i_left_present,
    input  logic signed [mbeg_pkg::MV_W-1:0]   i_left_mv_x,
    input  logic signed [mbeg_pkg::MV_W-1:0]   i_left_mv_y,
    input  logic signed [mbeg_pkg::COEF_W-1:0] i_coefficient,
    input  logic                               i_last_in_block,
    output logic                               o_push,
    output mbeg_pkg::t_job                     o_job,
    input  logic                               i_q_full,
    output logic                               o_wr_en,
    output logic [IDX_W:0]                     o_wr_addr,
    output logic signed [mbeg_pkg::COEF_W-1:0] o_wr_data,
    input  mbeg_pkg::t_free                    i_free
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_COEFFS - 1);

    logic                          r_mc_en,    n_mc_en;
    logic                          r_tr_en,    n_tr_en;
    logic                          r_q_en,     n_q_en;
    logic [mbeg_pkg::QP_W-1:0]     r_raw_off,  n_raw_off;
    logic                          r_div_busy, n_div_busy;
    logic [2:0]                    r_div_cnt,  n_div_cnt;
    logic [mbeg_pkg::QP_W-1:0]     r_div_d,    n_div_d;
    logic [mbeg_pkg::QP_W-1:0]     r_rem,      n_rem;
    logic [mbeg_pkg::QP_W-1:0]     r_quo,      n_quo;
    logic [mbeg_pkg::QP_W-1:0]     r_num,      n_num;
    logic                          r_mb_inter, n_mb_inter;
    logic [IDX_W-1:0]              r_fill,     n_fill;
    logic                          r_has_nz,   n_has_nz;
    logic                          r_wbank,    n_wbank;
    logic [1:0]                    r_busy,     n_busy;

    logic                          acc;
    logic                          cbp_mode;
    logic                          blk_nz;
    logic                          blk_end;
    logic [mbeg_pkg::QP_W:0]       rem_shift;
    logic [mbeg_pkg::QP_W-1:0]     off;
    logic signed [mbeg_pkg::COEF_W-1:0] sum_x, sum_y, pred_x, pred_y;

    assign o_stall = i_q_full || r_busy[r_wbank] || r_div_busy;
    assign acc     = i_valid && !o_stall;

    // Neighbor average, truncated toward zero.
    always_comb begin
        sum_x = (i_up_present ? mbeg_pkg::COEF_W'(i_up_mv_x) : '0)
              + (i_left_present ? mbeg_pkg::COEF_W'(i_left_mv_x) : '0);
        sum_y = (i_up_present ? mbeg_pkg::COEF_W'(i_up_mv_y) : '0)
              + (i_left_present ? mbeg_pkg::COEF_W'(i_left_mv_y) : '0);
        pred_x = sum_x;
        pred_y = sum_y;
        if (i_up_present && i_left_present) begin
            pred_x = $signed(sum_x + mbeg_pkg::COEF_W'(sum_x[mbeg_pkg::COEF_W-1])) >>> 1;
            pred_y = $signed(sum_y + mbeg_pkg::COEF_W'(sum_y[mbeg_pkg::COEF_W-1])) >>> 1;
        end
    end

    always_comb begin
        n_mc_en    = r_mc_en;
        n_tr_en    = r_tr_en;
        n_q_en     = r_q_en;
        n_raw_off  = r_raw_off;
        n_div_busy = r_div_busy;
        n_div_cnt  = r_div_cnt;
        n_div_d    = r_div_d;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_num      = r_num;
        n_mb_inter = r_mb_inter;
        n_fill     = r_fill;
        n_has_nz   = r_has_nz;
        n_wbank    = r_wbank;
        n_busy     = r_busy;

        cbp_mode = r_tr_en || (r_mc_en && r_mb_inter);
        blk_nz   = r_has_nz || (i_coefficient != '0);
        blk_end  = i_last_in_block || (r_fill == LAST_IDX);
        off      = r_q_en ? r_raw_off : mbeg_pkg::RAW_BASE;

        o_push        = 1'b0;
        o_job.kind    = mbeg_pkg::JOB_START;
        o_job.val0    = '0;
        o_job.val1    = '0;
        o_job.bank    = r_wbank;
        o_job.last_idx = mbeg_pkg::IDX_MAX_W'(r_fill);
        o_wr_en       = 1'b0;
        o_wr_addr     = {r_wbank, r_fill};
        o_wr_data     = i_coefficient;

        // Restoring divide of the fixed base by qp, one quotient bit a cycle.
        rem_shift = {r_rem, r_num[mbeg_pkg::QP_W-1]};
        if (r_div_busy) begin
            n_num = r_num << 1;
            if (rem_shift >= {1'b0, r_div_d}) begin
                n_rem = mbeg_pkg::QP_W'(rem_shift - {1'b0, r_div_d});
                n_quo = {r_quo[mbeg_pkg::QP_W-2:0], 1'b1};
            end else begin
                n_rem = rem_shift[mbeg_pkg::QP_W-1:0];
                n_quo = {r_quo[mbeg_pkg::QP_W-2:0], 1'b0};
            end
            n_div_cnt = r_div_cnt + 1'b1;
            if (r_div_cnt == 3'd7) begin
                n_div_busy = 1'b0;
                n_raw_off  = n_quo;
            end
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                mbeg_pkg::CFG_MC_EN: n_mc_en = i_cfg_data[0];
                mbeg_pkg::CFG_TR_EN: n_tr_en = i_cfg_data[0];
                mbeg_pkg::CFG_Q_EN:  n_q_en  = i_cfg_data[0];
                mbeg_pkg::CFG_QUANT_QP: begin
                    if (i_cfg_data == '0) begin
                        n_raw_off = mbeg_pkg::RAW_BASE;
                    end else begin
                        n_div_busy = 1'b1;
                        n_div_cnt  = '0;
                        n_div_d    = i_cfg_data;
                        n_rem      = '0;
                        n_quo      = '0;
                        n_num      = mbeg_pkg::RAW_BASE;
                    end
                end
                default: ;
            endcase
        end

        if (i_free.vld) begin
            n_busy[i_free.bank] = 1'b0;
        end

        if (acc) begin
            if (!i_mode) begin
                // Start of a macroblock: drop any partial block.
                n_mb_inter = i_inter_flag;
                n_fill     = '0;
                n_has_nz   = 1'b0;
                o_push     = 1'b1;
                if (i_inter_flag && r_mc_en) begin
                    o_job.kind = mbeg_pkg::JOB_VEC;
                    o_job.val0 = mbeg_pkg::VAL_W'(i_mv_x) - mbeg_pkg::VAL_W'(pred_x);
                    o_job.val1 = mbeg_pkg::VAL_W'(i_mv_y) - mbeg_pkg::VAL_W'(pred_y);
                end
            end else if (!cbp_mode) begin
                o_push     = 1'b1;
                o_job.kind = mbeg_pkg::JOB_RAW;
                o_job.val0 = mbeg_pkg::VAL_W'(i_coefficient)
                           - $signed({{(mbeg_pkg::VAL_W-mbeg_pkg::QP_W){1'b0}}, off});
            end else begin
                o_wr_en = 1'b1;
                if (blk_end) begin
                    o_push   = 1'b1;
                    n_fill   = '0;
                    n_has_nz = 1'b0;
                    if (blk_nz) begin
                        o_job.kind       = mbeg_pkg::JOB_BLK;
                        n_busy[r_wbank]  = 1'b1;
                        n_wbank          = !r_wbank;
                    end else begin
                        o_job.kind = mbeg_pkg::JOB_ZBLK;
                    end
                end else begin
                    n_fill   = r_fill + 1'b1;
                    n_has_nz = blk_nz;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_div_d <= n_div_d;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_num   <= n_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mc_en    <= 1'b1;
            r_tr_en    <= 1'b1;
            r_q_en     <= 1'b1;
            r_raw_off  <= mbeg_pkg::RAW_BASE;
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
            r_mb_inter <= 1'b0;
            r_fill     <= '0;
            r_has_nz   <= 1'b0;
            r_wbank    <= 1'b0;
            r_busy     <= '0;
        end else begin
            r_mc_en    <= n_mc_en;
            r_tr_en    <= n_tr_en;
            r_q_en     <= n_q_en;
            r_raw_off  <= n_raw_off;
            r_div_busy <= n_div_busy;
            r_div_cnt  <= n_div_cnt;
            r_mb_inter <= n_mb_inter;
            r_fill     <= n_fill;
            r_has_nz   <= n_has_nz;
            r_wbank    <= n_wbank;
            r_busy     <= n_busy;
        end
    end

endmodule

// ===== design/mbeg_back.sv =====
module mbeg_back #(
    parameter int IDX_W = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [IDX_W:0]                     i_wr_addr,
    input  logic signed [mbeg_pkg::COEF_W-1:0] i_wr_data,
    input  logic                               i_q_empty,
    input  mbeg_pkg::t_job                     i_head,
    output logic                               o_pop,
    output mbeg_pkg::t_free                    o_free,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [mbeg_pkg::WORD_W-1:0]        o_code_word,
    output logic [mbeg_pkg::LEN_W-1:0]         o_code_length,
    output logic                               o_last_of_run,
    output logic [mbeg_pkg::MB_W-1:0]          o_mb_bits_used,
    output logic [mbeg_pkg::TOT_W-1:0]         o_total_bits_used
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    localparam int MEM_DEPTH = 2 << IDX_W;

    logic signed [mbeg_pkg::COEF_W-1:0] r_mem [MEM_DEPTH];
    logic signed [mbeg_pkg::COEF_W-1:0] r_rd_data;

    t_state                          r_state,   n_state;
    mbeg_pkg::t_job                  r_job,     n_job;
    logic [IDX_W-1:0]                r_idx,     n_idx;
    logic                            r_second,  n_second;
    logic [mbeg_pkg::MB_W-1:0]       r_mb,      n_mb;
    logic [mbeg_pkg::MB_W-1:0]       r_mb_out,  n_mb_out;
    logic [mbeg_pkg::TOT_W-1:0]      r_tot,     n_tot;
    logic                            r_out_vld, n_out_vld;
    logic [mbeg_pkg::WORD_W-1:0]     r_word,    n_word;
    logic [mbeg_pkg::LEN_W-1:0]      r_len,     n_len;
    logic                            r_last,    n_last;

    logic                            out_free;
    logic                            is_blk;
    logic                            blk_end;
    logic signed [mbeg_pkg::VAL_W-1:0] g_val;
    logic [mbeg_pkg::VAL_W-1:0]      g_mag;
    logic                            g_pos;
    logic [mbeg_pkg::VAL_W:0]        g_cw;
    logic [mbeg_pkg::K_W-1:0]        g_k;
    logic [mbeg_pkg::LEN_W-1:0]      g_len;
    logic [mbeg_pkg::MB_W:0]         mb_sum;
    logic [mbeg_pkg::TOT_W:0]        tot_sum;

    assign o_valid           = r_out_vld;
    assign o_code_word       = r_word;
    assign o_code_length     = r_len;
    assign o_last_of_run     = r_last;
    assign o_mb_bits_used    = r_mb_out;
    assign o_total_bits_used = r_tot;

    // Signed order-0 exp-Golomb of the selected value.
    always_comb begin
        is_blk  = (r_job.kind == mbeg_pkg::JOB_BLK);
        blk_end = (r_idx == r_job.last_idx[IDX_W-1:0]);
        if (is_blk) begin
            g_val = mbeg_pkg::VAL_W'(r_rd_data);
        end else begin
            g_val = r_second ? r_job.val1 : r_job.val0;
        end
        g_pos = !g_val[mbeg_pkg::VAL_W-1] && (g_val != '0);
        g_mag = g_val[mbeg_pkg::VAL_W-1] ? mbeg_pkg::VAL_W'(-g_val) : mbeg_pkg::VAL_W'(g_val);
        g_cw  = {g_mag, 1'b0} - (mbeg_pkg::VAL_W+1)'(g_pos) + 1'b1;
        g_k   = '0;
        for (int i = 0; i <= mbeg_pkg::VAL_W; i++) begin
            if (g_cw[i]) begin
                g_k = mbeg_pkg::K_W'(i);
            end
        end
        g_len   = {g_k, 1'b0} + 1'b1;
        mb_sum  = {1'b0, r_mb} + (mbeg_pkg::MB_W+1)'(g_len);
        tot_sum = {1'b0, r_tot} + (mbeg_pkg::TOT_W+1)'(g_len);
    end

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_idx     = r_idx;
        n_second  = r_second;
        n_mb      = r_mb;
        n_mb_out  = r_mb_out;
        n_tot     = r_tot;
        n_out_vld = r_out_vld;
        n_word    = r_word;
        n_len     = r_len;
        n_last    = r_last;
        o_pop     = 1'b0;
        o_free    = '{vld: 1'b0, bank: r_job.bank};

        out_free = !r_out_vld || !i_stall;
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop    = 1'b1;
                    n_job    = i_head;
                    n_second = 1'b0;
                    n_idx    = '0;
                    case (i_head.kind) inside
                        mbeg_pkg::JOB_START: n_mb = '0;
                        mbeg_pkg::JOB_VEC: begin
                            n_mb    = '0;
                            n_state = S_EMIT;
                        end
                        mbeg_pkg::JOB_BLK: n_state = S_READ;
                        mbeg_pkg::JOB_RAW, mbeg_pkg::JOB_ZBLK: n_state = S_EMIT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    if (r_job.kind == mbeg_pkg::JOB_ZBLK) begin
                        // Pattern bit alone; counts stay.
                        n_word = '0;
                        n_len  = mbeg_pkg::LEN_W'(1);
                    end else begin
                        n_mb  = mb_sum[mbeg_pkg::MB_W] ? '1 : mb_sum[mbeg_pkg::MB_W-1:0];
                        n_tot = tot_sum[mbeg_pkg::TOT_W] ? '1 : tot_sum[mbeg_pkg::TOT_W-1:0];
                        n_word = mbeg_pkg::WORD_W'(g_cw);
                        n_len  = g_len;
                        // Merge the pattern bit ahead of the first codeword of a block.
                        if (is_blk && (r_idx == '0)) begin
                            n_word = mbeg_pkg::WORD_W'(g_cw)
                                   | (mbeg_pkg::WORD_W'(1) << g_len);
                            n_len  = g_len + 1'b1;
                        end
                    end
                    n_mb_out = n_mb;
                    case (r_job.kind)
                        mbeg_pkg::JOB_BLK: begin
                            n_last = blk_end;
                            if (blk_end) begin
                                o_free.vld = 1'b1;
                                n_state    = S_IDLE;
                            end else begin
                                n_idx   = r_idx + 1'b1;
                                n_state = S_READ;
                            end
                        end
                        mbeg_pkg::JOB_VEC: begin
                            n_last   = r_second;
                            n_second = 1'b1;
                            if (r_second) begin
                                n_state = S_IDLE;
                            end
                        end
                        default: begin
                            n_last  = 1'b1;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[{r_job.bank, r_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_idx    <= n_idx;
        r_second <= n_second;
        r_word   <= n_word;
        r_len    <= n_len;
        r_last   <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mb      <= '0;
            r_mb_out  <= '0;
            r_tot     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mb      <= n_mb;
            r_mb_out  <= n_mb_out;
            r_tot     <= n_tot;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

// ===== design/macroblock_exp_golomb_coder_top.sv =====
// channel   dir  handshake          payload
// cfg       in   i_cfg_we           i_cfg_index, i_cfg_data
// request   in   i_valid / o_stall  i_mode .. i_last_in_block
// result    out  o_valid / i_stall  o_code_word .. o_total_bits_used
//
// The front takes one request a cycle unless the job queue is full, the block
// bank it fills is still being emitted, or a quantizer divide started by a
// nonzero quant_param write is running. The back takes a job from the queue in
// its idle state, then emits a raw value or an all-zero block as one codeword
// and a vector pair as two; each buffered coefficient passes a read state, then
// an emit state, since the memory read is registered. Output stalls hold the back.
// Reset is synchronous and active low; the block memory is not cleared.
`include "assert_macros.svh"

module macroblock_exp_golomb_coder_top #(
    parameter int BLOCK_COEFFS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mbeg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mbeg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_mode,
    input  logic                               i_inter_flag,
    input  logic signed [mbeg_pkg::MV_W-1:0]   i_mv_x,
    input  logic signed [mbeg_pkg::MV_W-1:0]   i_mv_y,
    input  logic                               i_up_present,
    input  logic signed [mbeg_pkg::MV_W-1:0]   i_up_mv_x,
    input  logic signed [mbeg_pkg::MV_W-1:0]   i_up_mv_y,
    input  logic                               i_left_present,
    input  logic signed [mbeg_pkg::MV_W-1:0]   i_left_mv_x,
    input  logic signed [mbeg_pkg::MV_W-1:0]   i_left_mv_y,
    input  logic signed [mbeg_pkg::COEF_W-1:0] i_coefficient,
    input  logic                               i_last_in_block,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [mbeg_pkg::WORD_W-1:0]        o_code_word,
    output logic [mbeg_pkg::LEN_W-1:0]         o_code_length,
    output logic                               o_last_of_run,
    output logic [mbeg_pkg::MB_W-1:0]          o_mb_bits_used,
    output logic [mbeg_pkg::TOT_W-1:0]         o_total_bits_used
);

    localparam int IDX_W = $clog2(BLOCK_COEFFS);
    localparam logic [mbeg_pkg::LEN_W-1:0] MAX_LEN = mbeg_pkg::LEN_W'(mbeg_pkg::WORD_W);

    logic                               w_push;
    mbeg_pkg::t_job                     w_push_job;
    logic                               w_q_full;
    logic                               w_q_empty;
    logic                               w_pop;
    mbeg_pkg::t_job                     w_head;
    logic                               w_wr_en;
    logic [IDX_W:0]                     w_wr_addr;
    logic signed [mbeg_pkg::COEF_W-1:0] w_wr_data;
    mbeg_pkg::t_free                    w_free;

    mbeg_front #(
        .BLOCK_COEFFS (BLOCK_COEFFS),
        .IDX_W        (IDX_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_inter_flag    (i_inter_flag),
        .i_mv_x          (i_mv_x),
        .i_mv_y          (i_mv_y),
        .i_up_present    (i_up_present),
        .i_up_mv_x       (i_up_mv_x),
        .i_up_mv_y       (i_up_mv_y),
        .i_left_present  (i_left_present),
        .i_left_mv_x     (i_left_mv_x),
        .i_left_mv_y     (i_left_mv_y),
        .i_coefficient   (i_coefficient),
        .i_last_in_block (i_last_in_block),
        .o_push          (w_push),
        .o_job           (w_push_job),
        .i_q_full        (w_q_full),
        .o_wr_en         (w_wr_en),
        .o_wr_addr       (w_wr_addr),
        .o_wr_data       (w_wr_data),
        .i_free          (w_free)
    );

    mbeg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_q_empty)
    );

    mbeg_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_wr_en           (w_wr_en),
        .i_wr_addr         (w_wr_addr),
        .i_wr_data         (w_wr_data),
        .i_q_empty         (w_q_empty),
        .i_head            (w_head),
        .o_pop             (w_pop),
        .o_free            (w_free),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_code_word       (o_code_word),
        .o_code_length     (o_code_length),
        .o_last_of_run     (o_last_of_run),
        .o_mb_bits_used    (o_mb_bits_used),
        .o_total_bits_used (o_total_bits_used)
    );

    `ASSERT_IMPL(a_no_push_when_full, i_clk, i_rst_n, w_push, !w_q_full)
    `ASSERT_IMPL(a_no_pop_when_empty, i_clk, i_rst_n, w_pop, !w_q_empty)
    `ASSERT_IMPL(a_len_range, i_clk, i_rst_n, o_valid, (o_code_length != '0) && (o_code_length <= MAX_LEN))
    `ASSERT_IMPL(a_mb_le_total, i_clk, i_rst_n, o_valid, (mbeg_pkg::TOT_W'(o_mb_bits_used) <= o_total_bits_used))

endmodule

// ===== sim/mb_golomb_checker.sv =====
module mb_golomb_checker
    import mbeg_pkg::*;
#(
    parameter logic START_MODE   = 1'b0,
    parameter int   BLOCK_COEFFS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_req_valid,
    input  logic                      i_req_stall,
    input  logic                      i_mode,
    input  logic                      i_inter_flag,
    input  logic signed [MV_W-1:0]    i_mv_x,
    input  logic signed [MV_W-1:0]    i_mv_y,
    input  logic                      i_up_present,
    input  logic signed [MV_W-1:0]    i_up_mv_x,
    input  logic signed [MV_W-1:0]    i_up_mv_y,
    input  logic                      i_left_present,
    input  logic signed [MV_W-1:0]    i_left_mv_x,
    input  logic signed [MV_W-1:0]    i_left_mv_y,
    input  logic signed [COEF_W-1:0]  i_coefficient,
    input  logic                      i_last_in_block,
    input  logic                      i_res_valid,
    input  logic                      i_res_stall,
    input  logic [WORD_W-1:0]         i_code_word,
    input  logic [LEN_W-1:0]          i_code_length,
    input  logic                      i_last_of_run,
    input  logic [MB_W-1:0]           i_mb_bits_used,
    input  logic [TOT_W-1:0]          i_total_bits_used,
    output int                        o_pending,
    output int                        o_fail_count
);

    localparam int     MB_SAT    = 16383;
    localparam longint TOTAL_SAT = 64'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  len;
        logic              last;
        logic [MB_W-1:0]   mb_bits;
        logic [TOT_W-1:0]  total_bits;
    } t_codeword;

    t_codeword expected_codes[$];

    bit     mc_en;
    bit     tr_en;
    bit     q_en;
    int     raw_offset;
    int     block_vals[BLOCK_COEFFS];
    int     fill;
    bit     has_nonzero;
    bit     mb_inter;
    int     mb_bits;
    longint total_bits;
    int     fails;

    assign o_fail_count = fails;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        fails++;
    endtask

    // Signed order-0 exp-Golomb: returns the length, word is right aligned.
    function automatic int golomb(int v, output logic [WORD_W-1:0] word);
        int mag;
        int num;
        int k;
        mag = (v < 0) ? -v : v;
        num = 2 * mag;
        if (v > 0) num--;
        k = 0;
        while (k < 30 && ((2 << k) - 1) <= num) k++;
        word = WORD_W'(num + 1);
        return 2 * k + 1;
    endfunction

    function automatic void push_code(logic [WORD_W-1:0] word, int len, bit last);
        t_codeword cw;
        cw.word       = word;
        cw.len        = LEN_W'(len);
        cw.last       = last;
        cw.mb_bits    = MB_W'(mb_bits);
        cw.total_bits = TOT_W'(total_bits);
        expected_codes.push_back(cw);
    endfunction

    function automatic void code_value(int v, bit with_cbp, bit last);
        logic [WORD_W-1:0] word;
        int                len;
        len = golomb(v, word);
        mb_bits += len;
        if (mb_bits > MB_SAT) mb_bits = MB_SAT;
        total_bits += len;
        if (total_bits > TOTAL_SAT) total_bits = TOTAL_SAT;
        // merge the coded-block bit ahead of the codeword, not counted
        if (with_cbp) begin
            word = word | (WORD_W'(1) << len);
            len++;
        end
        push_code(word, len, last);
    endfunction

    function automatic void code_request();
        int pred_x;
        int pred_y;
        int used;
        int c;
        int n;
        if (i_mode == START_MODE) begin
            mb_inter    = i_inter_flag;
            mb_bits     = 0;
            fill        = 0;
            has_nonzero = 0;
            if (!(mb_inter && mc_en)) return;
            pred_x = 0;
            pred_y = 0;
            used   = 0;
            if (i_up_present) begin
                pred_x += i_up_mv_x;
                pred_y += i_up_mv_y;
                used++;
            end
            if (i_left_present) begin
                pred_x += i_left_mv_x;
                pred_y += i_left_mv_y;
                used++;
            end
            // average truncates toward zero
            if (used > 1) begin
                pred_x = pred_x / 2;
                pred_y = pred_y / 2;
            end
            code_value(int'(i_mv_x) - pred_x, 1'b0, 1'b0);
            code_value(int'(i_mv_y) - pred_y, 1'b0, 1'b1);
            return;
        end
        c = i_coefficient;
        if (!(tr_en || (mc_en && mb_inter))) begin
            code_value(c - (q_en ? raw_offset : int'(RAW_BASE)), 1'b0, 1'b1);
            return;
        end
        if (fill < BLOCK_COEFFS) begin
            block_vals[fill] = c;
            fill++;
        end
        if (c != 0) has_nonzero = 1;
        if (!(i_last_in_block || fill >= BLOCK_COEFFS)) return;
        n    = fill;
        fill = 0;
        if (!has_nonzero) begin
            push_code('0, 1, 1'b1);
            return;
        end
        has_nonzero = 0;
        for (int i = 0; i < n; i++) code_value(block_vals[i], i == 0, i == n - 1);
    endfunction

    function automatic void apply_config();
        case (i_cfg_index)
            CFG_MC_EN: mc_en = i_cfg_data[0];
            CFG_TR_EN: tr_en = i_cfg_data[0];
            CFG_Q_EN:  q_en  = i_cfg_data[0];
            CFG_QUANT_QP: begin
                raw_offset = (i_cfg_data == 0) ? int'(RAW_BASE)
                                               : int'(RAW_BASE) / int'(i_cfg_data);
            end
            default: ;
        endcase
    endfunction

    task automatic check_result();
        t_codeword want;
        if (expected_codes.size() == 0) begin
            report("codeword with nothing outstanding", i_code_word, '0);
            return;
        end
        want = expected_codes.pop_front();
        if (i_code_word != want.word) report("code_word", i_code_word, want.word);
        if (i_code_length != want.len) report("code_length", i_code_length, want.len);
        if (i_last_of_run != want.last) report("last_of_run", i_last_of_run, want.last);
        if (i_mb_bits_used != want.mb_bits)
            report("mb_bits_used", i_mb_bits_used, want.mb_bits);
        if (i_total_bits_used != want.total_bits)
            report("total_bits_used", i_total_bits_used, want.total_bits);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mc_en       = 1;
            tr_en       = 1;
            q_en        = 1;
            raw_offset  = int'(RAW_BASE);
            fill        = 0;
            has_nonzero = 0;
            mb_inter    = 0;
            mb_bits     = 0;
            total_bits  = 0;
            expected_codes.delete();
        end else begin
            if (i_res_valid && !i_res_stall) check_result();
            if (i_cfg_we) apply_config();
            if (i_req_valid && !i_req_stall) code_request();
        end
        o_pending <= expected_codes.size();
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import mbeg_pkg::*;

    localparam int   BLOCK_COEFFS = 64;
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_COEF    = 1'b1;
    localparam int   DRAIN_CYCLES = 32;
    localparam int   PHASE_ITEMS  = 32;
    localparam int   CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic                     mode;
        logic                     inter_flag;
        logic signed [MV_W-1:0]   mv_x;
        logic signed [MV_W-1:0]   mv_y;
        logic                     up_present;
        logic signed [MV_W-1:0]   up_mv_x;
        logic signed [MV_W-1:0]   up_mv_y;
        logic                     left_present;
        logic signed [MV_W-1:0]   left_mv_x;
        logic signed [MV_W-1:0]   left_mv_y;
        logic signed [COEF_W-1:0] coefficient;
        logic                     last_in_block;
    } t_request;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic                     i_mode;
    logic                     i_inter_flag;
    logic signed [MV_W-1:0]   i_mv_x;
    logic signed [MV_W-1:0]   i_mv_y;
    logic                     i_up_present;
    logic signed [MV_W-1:0]   i_up_mv_x;
    logic signed [MV_W-1:0]   i_up_mv_y;
    logic                     i_left_present;
    logic signed [MV_W-1:0]   i_left_mv_x;
    logic signed [MV_W-1:0]   i_left_mv_y;
    logic signed [COEF_W-1:0] i_coefficient;
    logic                     i_last_in_block;
    logic                     o_valid;
    logic                     i_stall;
    logic [WORD_W-1:0]        o_code_word;
    logic [LEN_W-1:0]         o_code_length;
    logic                     o_last_of_run;
    logic [MB_W-1:0]          o_mb_bits_used;
    logic [TOT_W-1:0]         o_total_bits_used;

    int pending;
    int fail_count;
    int sent;
    int cycle_count;
    bit calm;

    always #5 i_clk = ~i_clk;

    macroblock_exp_golomb_coder_top #(
        .BLOCK_COEFFS(BLOCK_COEFFS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_inter_flag     (i_inter_flag),
        .i_mv_x           (i_mv_x),
        .i_mv_y           (i_mv_y),
        .i_up_present     (i_up_present),
        .i_up_mv_x        (i_up_mv_x),
        .i_up_mv_y        (i_up_mv_y),
        .i_left_present   (i_left_present),
        .i_left_mv_x      (i_left_mv_x),
        .i_left_mv_y      (i_left_mv_y),
        .i_coefficient    (i_coefficient),
        .i_last_in_block  (i_last_in_block),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_code_word      (o_code_word),
        .o_code_length    (o_code_length),
        .o_last_of_run    (o_last_of_run),
        .o_mb_bits_used   (o_mb_bits_used),
        .o_total_bits_used(o_total_bits_used)
    );

    mb_golomb_checker #(
        .START_MODE  (MODE_START),
        .BLOCK_COEFFS(BLOCK_COEFFS)
    ) u_golomb_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_req_valid      (i_valid),
        .i_req_stall      (o_stall),
        .i_mode           (i_mode),
        .i_inter_flag     (i_inter_flag),
        .i_mv_x           (i_mv_x),
        .i_mv_y           (i_mv_y),
        .i_up_present     (i_up_present),
        .i_up_mv_x        (i_up_mv_x),
        .i_up_mv_y        (i_up_mv_y),
        .i_left_present   (i_left_present),
        .i_left_mv_x      (i_left_mv_x),
        .i_left_mv_y      (i_left_mv_y),
        .i_coefficient    (i_coefficient),
        .i_last_in_block  (i_last_in_block),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_code_word      (o_code_word),
        .i_code_length    (o_code_length),
        .i_last_of_run    (o_last_of_run),
        .i_mb_bits_used   (o_mb_bits_used),
        .i_total_bits_used(o_total_bits_used),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    always @(posedge i_clk) i_stall <= !calm && ($urandom_range(0, 99) < 12);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_request noise_request();
        logic [95:0] bits;
        bits = {$urandom(), $urandom(), $urandom()};
        return t_request'(bits[$bits(t_request)-1:0]);
    endfunction

    function automatic t_request vec_req(bit inter, int mvx, int mvy, bit up_p, int upx,
                                         int upy, bit left_p, int lx, int ly);
        t_request r;
        r              = noise_request();
        r.mode         = MODE_START;
        r.inter_flag   = inter;
        r.mv_x         = MV_W'(mvx);
        r.mv_y         = MV_W'(mvy);
        r.up_present   = up_p;
        r.up_mv_x      = MV_W'(upx);
        r.up_mv_y      = MV_W'(upy);
        r.left_present = left_p;
        r.left_mv_x    = MV_W'(lx);
        r.left_mv_y    = MV_W'(ly);
        return r;
    endfunction

    function automatic t_request coef_req(int c, bit last);
        t_request r;
        r               = noise_request();
        r.mode          = MODE_COEF;
        r.coefficient   = COEF_W'(c);
        r.last_in_block = last;
        return r;
    endfunction

    function automatic int rand_coef();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 0;
            4:          return -2048;
            5:          return 2047;
            6, 7:       return int'($urandom_range(0, 16)) - 8;
            default:    return int'($urandom_range(0, 4095)) - 2048;
        endcase
    endfunction

    task automatic send_request(t_request r);
        if (!calm && $urandom_range(0, 99) < 12) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_mode          <= r.mode;
        i_inter_flag    <= r.inter_flag;
        i_mv_x          <= r.mv_x;
        i_mv_y          <= r.mv_y;
        i_up_present    <= r.up_present;
        i_up_mv_x       <= r.up_mv_x;
        i_up_mv_y       <= r.up_mv_y;
        i_left_present  <= r.left_present;
        i_left_mv_x     <= r.left_mv_x;
        i_left_mv_y     <= r.left_mv_y;
        i_coefficient   <= r.coefficient;
        i_last_in_block <= r.last_in_block;
        // hold the request until the block takes it
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(bit mc, bit tr, bit qen, logic [CFG_DATA_W-1:0] qp);
        write_reg(CFG_MC_EN, CFG_DATA_W'(mc));
        write_reg(CFG_TR_EN, CFG_DATA_W'(tr));
        write_reg(CFG_Q_EN, CFG_DATA_W'(qen));
        write_reg(CFG_QUANT_QP, qp);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for every outstanding codeword, then let the block go quiet.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_macroblock();
        t_request r;
        int       blocks;
        int       len;
        int       sel;
        bit       zero_blk;
        bit       full_flag;
        bit       broken;
        if ($urandom_range(0, 19) == 0) send_request(noise_request());
        r      = noise_request();
        r.mode = MODE_START;
        send_request(r);
        blocks = $urandom_range(1, 3);
        for (int b = 0; b < blocks; b++) begin
            sel = $urandom_range(0, 19);
            if (sel < 14) len = $urandom_range(1, 8);
            else if (sel < 17) len = $urandom_range(9, BLOCK_COEFFS - 1);
            else len = BLOCK_COEFFS;
            zero_blk  = $urandom_range(0, 4) == 0;
            full_flag = $urandom_range(0, 1);
            broken    = $urandom_range(0, 9) == 0;
            // a broken block may stop early and never sends its end marker
            if (broken) len = $urandom_range(1, len);
            for (int i = 0; i < len; i++)
                send_request(coef_req(zero_blk ? 0 : rand_coef(),
                    i == len - 1 && !broken && (len < BLOCK_COEFFS || full_flag)));
        end
    endtask

    initial begin
        int target;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        i_valid         <= 1'b0;
        i_stall         <= 1'b0;
        i_mode          <= MODE_START;
        i_inter_flag    <= 1'b0;
        i_mv_x          <= '0;
        i_mv_y          <= '0;
        i_up_present    <= 1'b0;
        i_up_mv_x       <= '0;
        i_up_mv_y       <= '0;
        i_left_present  <= 1'b0;
        i_left_mv_x     <= '0;
        i_left_mv_y     <= '0;
        i_coefficient   <= '0;
        i_last_in_block <= 1'b0;
        cycle_count     <= 0;
        sent = 0;
        calm = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(1, 1, 1, 1);
        // vector extremes, one neighbor, odd negative sum, no neighbors
        send_request(vec_req(1, 1023, -1024, 1, -1024, 1023, 1, -1024, 1023));
        send_request(vec_req(1, 0, 0, 1, -3, 5, 0, 0, 0));
        send_request(vec_req(1, 0, 0, 1, -3, 3, 1, 0, 0));
        send_request(vec_req(1, -1024, 1023, 0, 0, 0, 0, 0, 0));
        // widest merged codeword leads the block
        send_request(coef_req(-2048, 0));
        send_request(coef_req(2047, 0));
        send_request(coef_req(0, 0));
        send_request(coef_req(1, 0));
        send_request(coef_req(-1, 1));
        send_request(coef_req(0, 0));
        send_request(coef_req(0, 1));
        // intra start codes nothing, then leave a partial block behind
        send_request(vec_req(0, 5, 5, 1, 1, 1, 1, 2, 2));
        send_request(coef_req(5, 1));
        send_request(coef_req(7, 0));
        settle();

        set_config(0, 0, 1, 255);
        send_request(coef_req(-2048, 0));
        send_request(coef_req(2047, 0));
        send_request(coef_req(0, 1));
        settle();

        // the partial block resumes once block mode is back
        set_config(0, 1, 1, 1);
        send_request(coef_req(3, 1));
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_config(1, 1, 1, 1);
                1: set_config(0, 0, 1, 255);
                2: set_config(1, 0, 1, 3);
                3: set_config(0, 1, 0, 128);
                4: set_config(1, 0, 1, 0);
                default: set_config(0, 0, 0, 7);
            endcase
            calm   = (p == 3);
            target = sent + PHASE_ITEMS;
            while (sent < target) send_macroblock();
            settle();
        end

        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/mbeg_pkg.sv
design/mbeg_queue.sv
design/mbeg_front.sv
design/mbeg_back.sv
design/macroblock_exp_golomb_coder_top.sv
sim/mb_golomb_checker.sv
sim/tb_top.sv
